// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, off while reset is asserted.
`define TPVW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define TPVW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/tpvw_pkg.sv =====
// Shared constants and types of the trilinear partial-volume weights unit.
package tpvw_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int MAX_SIZE      = 1024;

  localparam int COORD_W     = 19;
  localparam int SIZE_W      = 11;
  localparam int CORNER_W    = 8;
  localparam int N_CORNER    = 8;
  localparam int N_AXIS      = 3;
  localparam int WEIGHT_W    = 25;
  localparam int WEIGHT_FRAC = 24;
  localparam int VALUE_W     = 16;
  localparam int VALUE_FRAC  = 8;
  localparam int SIZE_RESET  = 256;

  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  localparam int IN_DATA_W   = 128;
  localparam int OUT_DATA_W  = N_CORNER * WEIGHT_W + VALUE_W;
  localparam int OUT_USER_W  = 1;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef logic [N_CORNER-1:0][CORNER_W-1:0] corners_t;

  typedef struct packed {
    logic              ok;
    logic [SIZE_W-1:0] lim;
  } axis_lim_t;

  typedef struct packed {
    axis_lim_t z;
    axis_lim_t y;
    axis_lim_t x;
  } vol_lim_t;

endpackage

// ===== sv/tpvw_cfg.sv =====
// Size registers on the APB port and the per-axis limits derived from them.
module tpvw_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpvw_pkg::APB_AW-1:0]   paddr,
  input  logic [tpvw_pkg::APB_DW-1:0]   pwdata,
  output logic [tpvw_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output tpvw_pkg::vol_lim_t            lim_o
);

  localparam int SW    = tpvw_pkg::SIZE_W;
  localparam int SAT   = (tpvw_pkg::MAX_SIZE < (1 << SW)) ? tpvw_pkg::MAX_SIZE : (1 << SW) - 1;
  localparam logic [SW-1:0] SAT_V = SW'(SAT);

  logic [SW-1:0] size_x_q, size_y_q, size_z_q;
  logic          wr;
  logic [1:0]    idx;

  function automatic tpvw_pkg::axis_lim_t axis_lim(input logic [SW-1:0] s);
    tpvw_pkg::axis_lim_t r;
    logic [SW-1:0]       eff;
    eff   = (s > SAT_V) ? SAT_V : s;
    r.ok  = (eff >= SW'(2));
    r.lim = eff - SW'(1);
    return r;
  endfunction

  assign pready = 1'b1;
  assign idx    = paddr[tpvw_pkg::APB_AW-1:2];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SW'(tpvw_pkg::SIZE_RESET);
      size_y_q <= SW'(tpvw_pkg::SIZE_RESET);
      size_z_q <= SW'(tpvw_pkg::SIZE_RESET);
    end else if (wr) begin
      case (idx)
        tpvw_pkg::REG_SIZE_X: size_x_q <= pwdata[SW-1:0];
        tpvw_pkg::REG_SIZE_Y: size_y_q <= pwdata[SW-1:0];
        tpvw_pkg::REG_SIZE_Z: size_z_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tpvw_pkg::REG_SIZE_X: prdata = tpvw_pkg::APB_DW'(size_x_q);
      tpvw_pkg::REG_SIZE_Y: prdata = tpvw_pkg::APB_DW'(size_y_q);
      tpvw_pkg::REG_SIZE_Z: prdata = tpvw_pkg::APB_DW'(size_z_q);
      default:              prdata = '0;
    endcase
  end

  assign lim_o.x = axis_lim(size_x_q);
  assign lim_o.y = axis_lim(size_y_q);
  assign lim_o.z = axis_lim(size_z_q);

endmodule

// ===== sv/tpvw_front.sv =====
// Range check and fraction split of the three coordinates, one register stage.
module tpvw_front #(
  parameter int FRAC_BITS = tpvw_pkg::FRAC_BITS_DEF
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  tpvw_pkg::vol_lim_t                                    lim_i,
  input  logic                                                  in_valid_i,
  output logic                                                  in_ready_o,
  input  logic [tpvw_pkg::N_AXIS-1:0][tpvw_pkg::COORD_W-1:0]    coord_i,
  input  tpvw_pkg::corners_t                                    corners_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic                                                  inside_o,
  output logic [tpvw_pkg::N_AXIS-1:0][FRAC_BITS-1:0]            frac_o,
  output logic [tpvw_pkg::N_AXIS-1:0][FRAC_BITS:0]              comp_o,
  output tpvw_pkg::corners_t                                    corners_o
);

  localparam int CW   = tpvw_pkg::COORD_W;
  localparam int IPW  = CW - 1 - FRAC_BITS;
  localparam int CMPW = (IPW > tpvw_pkg::SIZE_W) ? IPW : tpvw_pkg::SIZE_W;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  tpvw_pkg::axis_lim_t [tpvw_pkg::N_AXIS-1:0] lim_arr;
  logic [tpvw_pkg::N_AXIS-1:0]                 ok;
  logic                                        inside_d;
  logic [tpvw_pkg::N_AXIS-1:0][FRAC_BITS-1:0]  frac_d;
  logic [tpvw_pkg::N_AXIS-1:0][FRAC_BITS:0]    comp_d;
  logic                                        vld_q;
  logic                                        en;
  logic                                        inside_q;
  logic [tpvw_pkg::N_AXIS-1:0][FRAC_BITS-1:0]  frac_q;
  logic [tpvw_pkg::N_AXIS-1:0][FRAC_BITS:0]    comp_q;
  tpvw_pkg::corners_t                          corners_q;

  assign lim_arr = {lim_i.z, lim_i.y, lim_i.x};

  always_comb begin
    for (int a = 0; a < tpvw_pkg::N_AXIS; a++) begin
      ok[a] = lim_arr[a].ok && !coord_i[a][CW-1] &&
              (CMPW'(coord_i[a][CW-2:FRAC_BITS]) < CMPW'(lim_arr[a].lim));
    end
    inside_d = &ok;
    for (int a = 0; a < tpvw_pkg::N_AXIS; a++) begin
      frac_d[a] = inside_d ? coord_i[a][FRAC_BITS-1:0] : '0;
      comp_d[a] = inside_d ? (ONE - {1'b0, coord_i[a][FRAC_BITS-1:0]}) : '0;
    end
  end

  assign en         = !vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      inside_q  <= inside_d;
      frac_q    <= frac_d;
      comp_q    <= comp_d;
      corners_q <= corners_i;
    end
  end

  assign out_valid_o = vld_q;
  assign inside_o    = inside_q;
  assign frac_o      = frac_q;
  assign comp_o      = comp_q;
  assign corners_o   = corners_q;

endmodule

// ===== sv/tpvw_weights.sv =====
// Two multiply stages that form the eight partial-volume weight products.
module tpvw_weights #(
  parameter int FRAC_BITS = tpvw_pkg::FRAC_BITS_DEF
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  logic                                                     in_valid_i,
  output logic                                                     in_ready_o,
  input  logic                                                     inside_i,
  input  logic [tpvw_pkg::N_AXIS-1:0][FRAC_BITS-1:0]               frac_i,
  input  logic [tpvw_pkg::N_AXIS-1:0][FRAC_BITS:0]                 comp_i,
  input  tpvw_pkg::corners_t                                       corners_i,
  output logic                                                     out_valid_o,
  input  logic                                                     out_ready_i,
  output logic                                                     inside_o,
  output logic [tpvw_pkg::N_CORNER-1:0][3*FRAC_BITS:0]             prod_o,
  output tpvw_pkg::corners_t                                       corners_o
);

  localparam int TW = FRAC_BITS + 1;
  localparam int YW = 2 * FRAC_BITS + 1;
  localparam int PW = 3 * FRAC_BITS + 1;

  logic [3:0][YW-1:0]                  yz_d, yz_q;
  logic [1:0][TW-1:0]                  tx_q;
  logic                                inside2_q, inside3_q;
  tpvw_pkg::corners_t                  corners2_q, corners3_q;
  logic [tpvw_pkg::N_CORNER-1:0][PW-1:0] prod_d, prod_q;
  logic                                v2_q, v3_q;
  logic                                en2, en3;
  logic [TW-1:0]                       ty, tz;

  always_comb begin
    ty = '0;
    tz = '0;
    for (int bc = 0; bc < 4; bc++) begin
      ty       = bc[1] ? {1'b0, frac_i[1]} : comp_i[1];
      tz       = bc[0] ? {1'b0, frac_i[2]} : comp_i[2];
      yz_d[bc] = YW'(ty) * YW'(tz);
    end
  end

  always_comb begin
    for (int k = 0; k < tpvw_pkg::N_CORNER; k++) begin
      prod_d[k] = PW'(tx_q[k[2]]) * PW'(yz_q[k[1:0]]);
    end
  end

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign in_ready_o = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en2) begin
        v2_q <= in_valid_i;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && in_valid_i) begin
      yz_q       <= yz_d;
      tx_q       <= {{1'b0, frac_i[0]}, comp_i[0]};
      inside2_q  <= inside_i;
      corners2_q <= corners_i;
    end
    if (en3 && v2_q) begin
      prod_q     <= prod_d;
      inside3_q  <= inside2_q;
      corners3_q <= corners2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign inside_o    = inside3_q;
  assign prod_o      = prod_q;
  assign corners_o   = corners3_q;

endmodule

// ===== sv/tpvw_value.sv =====
// Weight scaling, corner products, sum tree and the output register.
module tpvw_value #(
  parameter int FRAC_BITS = tpvw_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic                                          inside_i,
  input  logic [tpvw_pkg::N_CORNER-1:0][3*FRAC_BITS:0]  prod_i,
  input  tpvw_pkg::corners_t                            corners_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [tpvw_pkg::OUT_DATA_W-1:0]               out_data_o,
  output logic [tpvw_pkg::OUT_USER_W-1:0]               out_user_o
);

  localparam int PW  = 3 * FRAC_BITS + 1;
  localparam int SW  = 3 * FRAC_BITS + tpvw_pkg::CORNER_W;
  localparam int WW  = tpvw_pkg::WEIGHT_W;
  localparam int WF  = tpvw_pkg::WEIGHT_FRAC;
  localparam int VW  = tpvw_pkg::VALUE_W;
  localparam int VF  = tpvw_pkg::VALUE_FRAC;
  localparam int NC  = tpvw_pkg::N_CORNER;

  logic [NC-1:0][SW-1:0]   mp_d, mp_q;
  logic [NC-1:0][WW-1:0]   w_d, w4_q, w5_q, w6_q;
  logic [PW+WF-1:0]        wide_w;
  logic [3:0][SW-1:0]      s5_d, s5_q;
  logic [SW-1:0]           total;
  logic [SW+VF-1:0]        wide_v;
  logic [VW-1:0]           interp_d, interp_q;
  logic                    inside4_q, inside5_q, inside6_q;
  logic                    v4_q, v5_q, v6_q;
  logic                    en4, en5, en6;

  always_comb begin
    wide_w = '0;
    for (int k = 0; k < NC; k++) begin
      mp_d[k] = SW'(prod_i[k]) * SW'(corners_i[k]);
      wide_w  = {prod_i[k], {WF{1'b0}}} >> (3 * FRAC_BITS);
      w_d[k]  = wide_w[WW-1:0];
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      s5_d[j] = mp_q[2*j] + mp_q[2*j+1];
    end
  end

  always_comb begin
    total    = (s5_q[0] + s5_q[1]) + (s5_q[2] + s5_q[3]);
    wide_v   = {total, {VF{1'b0}}} >> (3 * FRAC_BITS);
    interp_d = wide_v[VW-1:0];
  end

  assign en6        = !v6_q || out_ready_i;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign in_ready_o = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= in_valid_i;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && in_valid_i) begin
      mp_q      <= mp_d;
      w4_q      <= w_d;
      inside4_q <= inside_i;
    end
    if (en5 && v4_q) begin
      s5_q      <= s5_d;
      w5_q      <= w4_q;
      inside5_q <= inside4_q;
    end
    if (en6 && v5_q) begin
      interp_q  <= interp_d;
      w6_q      <= w5_q;
      inside6_q <= inside5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = {interp_q, w6_q};
  assign out_user_o  = inside6_q;

endmodule

// ===== sv/trilinear_partial_volume_weights_unit.sv =====
// Trilinear partial-volume weights unit: takes one point with its eight corner
// voxels per beat and returns the eight corner weights and the interpolated
// value. A new beat is taken every cycle unless the output stalls; stages are
// the range-check stage, two weight-multiply stages, the corner-product stage
// and the two-level sum tree ending in the output register. A stalled output
// only holds back beats behind it, bubbles in between are still filled.
module trilinear_partial_volume_weights_unit #(
  parameter int FRAC_BITS = tpvw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpvw_pkg::APB_AW-1:0]         paddr,
  input  logic [tpvw_pkg::APB_DW-1:0]         pwdata,
  output logic [tpvw_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coord_x, coord_y, coord_z, corner_000 .. corner_111, zero fill
  input  logic [tpvw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // weight_000 .. weight_111, interp_value
  output logic [tpvw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // inside_res
  output logic [tpvw_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

  localparam int CW  = tpvw_pkg::COORD_W;
  localparam int NA  = tpvw_pkg::N_AXIS;
  localparam int NC  = tpvw_pkg::N_CORNER;
  localparam int CRW = tpvw_pkg::CORNER_W;

  tpvw_pkg::vol_lim_t                    lim;
  logic [NA-1:0][CW-1:0]                 coord;
  tpvw_pkg::corners_t                    corners_in;

  logic                                  f_valid, f_ready, f_inside;
  logic [NA-1:0][FRAC_BITS-1:0]          f_frac;
  logic [NA-1:0][FRAC_BITS:0]            f_comp;
  tpvw_pkg::corners_t                    f_corners;

  logic                                  w_valid, w_ready, w_inside;
  logic [NC-1:0][3*FRAC_BITS:0]          w_prod;
  tpvw_pkg::corners_t                    w_corners;

  assign coord      = s_axis_tdata[NA*CW-1:0];
  assign corners_in = s_axis_tdata[NA*CW+NC*CRW-1:NA*CW];

  tpvw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lim_o   (lim)
  );

  tpvw_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .coord_i     (coord),
    .corners_i   (corners_in),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .inside_o    (f_inside),
    .frac_o      (f_frac),
    .comp_o      (f_comp),
    .corners_o   (f_corners)
  );

  tpvw_weights #(.FRAC_BITS(FRAC_BITS)) u_weights (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .inside_i    (f_inside),
    .frac_i      (f_frac),
    .comp_i      (f_comp),
    .corners_i   (f_corners),
    .out_valid_o (w_valid),
    .out_ready_i (w_ready),
    .inside_o    (w_inside),
    .prod_o      (w_prod),
    .corners_o   (w_corners)
  );

  tpvw_value #(.FRAC_BITS(FRAC_BITS)) u_value (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (w_valid),
    .in_ready_o  (w_ready),
    .inside_i    (w_inside),
    .prod_i      (w_prod),
    .corners_i   (w_corners),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ===== sv/tpvw_checker.sv =====
// Port-level checks of the result stream, bound to the top level.
`include "assert_macros.svh"

module tpvw_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [tpvw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic [tpvw_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  `TPVW_ASSERT(a_outside_zero, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0), "outside beat carries nonzero data")

  `TPVW_ASSERT(a_value_bound, m_axis_tvalid |-> (m_axis_tdata[215:200] <= 16'hFF00), "interpolated value above full scale")

  `TPVW_ASSERT(a_weight_bound, m_axis_tvalid |-> ((m_axis_tdata[24:0] <= 25'h1000000) && (m_axis_tdata[49:25] <= 25'h1000000) && (m_axis_tdata[74:50] <= 25'h1000000) && (m_axis_tdata[99:75] <= 25'h1000000) && (m_axis_tdata[124:100] <= 25'h1000000) && (m_axis_tdata[149:125] <= 25'h1000000) && (m_axis_tdata[174:150] <= 25'h1000000) && (m_axis_tdata[199:175] <= 25'h1000000)), "weight above one")

  `TPVW_ASSERT(a_stall_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result beat changed")

endmodule

bind trilinear_partial_volume_weights_unit tpvw_checker u_tpvw_checker (.*);

// ===== bench/trilinear_partial_volume_weights_unit_test.sv =====
// Self-checking testbench of the trilinear partial-volume weights unit.
`timescale 1ns / 1ps

module trilinear_partial_volume_weights_unit_test;

  localparam int FRAC = tpvw_pkg::FRAC_BITS_DEF;
  localparam int COORD_MAX = (1 << (tpvw_pkg::COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (tpvw_pkg::COORD_W - 1));
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    tpvw_pkg::corners_t                   corner;
    logic signed [tpvw_pkg::COORD_W-1:0]  z;
    logic signed [tpvw_pkg::COORD_W-1:0]  y;
    logic signed [tpvw_pkg::COORD_W-1:0]  x;
  } point_t;

  typedef struct packed {
    logic                                                 in_vol;
    logic [tpvw_pkg::VALUE_W-1:0]                         value;
    logic [tpvw_pkg::N_CORNER-1:0][tpvw_pkg::WEIGHT_W-1:0] weight;
  } res_t;

  typedef struct {
    int          x;
    int          y;
    int          z;
    logic [63:0] vox;
    bit          typed;
    bit          in_vol;
    int          w000;
    int          value;
  } dir_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [tpvw_pkg::APB_AW-1:0]       paddr = '0;
  logic [tpvw_pkg::APB_DW-1:0]       pwdata = '0;
  logic [tpvw_pkg::APB_DW-1:0]       prdata;
  logic                              pready;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [tpvw_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [tpvw_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
  logic [tpvw_pkg::OUT_USER_W-1:0]   m_axis_tuser;

  logic [tpvw_pkg::SIZE_W-1:0] vol_size [tpvw_pkg::N_AXIS];
  res_t              pending_res [$];
  int                err_cnt = 0;
  int                beats_done = 0;
  int                inside_cnt = 0;
  int                settings_cnt = 1;
  bit                calm = 1'b0;
  bit                hold_off = 1'b0;

  dir_row_t dir_tab [16] = '{
    '{0, 0, 0, 64'hABAB_ABAB_ABAB_ABAB, 1, 1, 1 << 24, 'hAB00},
    '{-1, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0},
    '{0, -1, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0},
    '{0, 0, -1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0},
    '{65280, 0, 0, 64'h8080_8080_8080_8080, 1, 0, 0, 0},
    '{0, 65280, 0, 64'h8080_8080_8080_8080, 1, 0, 0, 0},
    '{0, 0, 65280, 64'h8080_8080_8080_8080, 1, 0, 0, 0},
    '{COORD_MAX, COORD_MAX, COORD_MAX, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0},
    '{COORD_MIN, COORD_MIN, COORD_MIN, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0},
    '{256, 512, 768, 64'h0102_0304_0506_0708, 1, 1, 1 << 24, 'h0800},
    '{65024, 65024, 65024, 64'hFFEE_DDCC_BBAA_9911, 1, 1, 1 << 24, 'h1100},
    '{65279, 65279, 65279, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0},
    '{128, 128, 128, 64'h00FF_00FF_00FF_00FF, 0, 0, 0, 0},
    '{1, 0, 255, 64'h1234_5678_9ABC_DEF0, 0, 0, 0, 0},
    '{65279, 0, 128, 64'hFF00_0000_0000_0000, 0, 0, 0, 0},
    '{300, 40000, 1000, 64'h0000_0000_0000_00FF, 0, 0, 0, 0}
  };

  trilinear_partial_volume_weights_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int eff_size(logic [tpvw_pkg::SIZE_W-1:0] sz);
    return (sz > tpvw_pkg::MAX_SIZE) ? tpvw_pkg::MAX_SIZE : int'(sz);
  endfunction

  function automatic bit axis_in(logic signed [tpvw_pkg::COORD_W-1:0] c,
                                 logic [tpvw_pkg::SIZE_W-1:0] sz);
    int s;
    int ci;
    s = eff_size(sz);
    ci = c;
    return s >= 2 && ci >= 0 && ci < ((s - 1) << FRAC);
  endfunction

  function automatic res_t interp_point(point_t pt);
    res_t        r;
    logic [8:0]  tx [2];
    logic [8:0]  ty [2];
    logic [8:0]  tz [2];
    logic [63:0] prod;
    logic [63:0] total;
    r = '0;
    total = '0;
    if (!axis_in(pt.x, vol_size[0]) || !axis_in(pt.y, vol_size[1]) ||
        !axis_in(pt.z, vol_size[2]))
      return r;
    tx[1] = 9'(pt.x[FRAC-1:0]);
    ty[1] = 9'(pt.y[FRAC-1:0]);
    tz[1] = 9'(pt.z[FRAC-1:0]);
    tx[0] = 9'(1 << FRAC) - tx[1];
    ty[0] = 9'(1 << FRAC) - ty[1];
    tz[0] = 9'(1 << FRAC) - tz[1];
    r.in_vol = 1'b1;
    for (int k = 0; k < tpvw_pkg::N_CORNER; k++) begin
      prod = 64'(tx[k[2]]) * 64'(ty[k[1]]) * 64'(tz[k[0]]);
      total += prod * 64'(pt.corner[k]);
      r.weight[k] = tpvw_pkg::WEIGHT_W'(prod >> (3 * FRAC - tpvw_pkg::WEIGHT_FRAC));
    end
    r.value = tpvw_pkg::VALUE_W'(total >> (3 * FRAC - tpvw_pkg::VALUE_FRAC));
    return r;
  endfunction

  function automatic logic signed [tpvw_pkg::COORD_W-1:0] rand_coord(
    logic [tpvw_pkg::SIZE_W-1:0] sz, bit wide);
    int s;
    int lim;
    int pick;
    s = eff_size(sz);
    lim = (s < 2) ? 0 : (s - 1) << FRAC;
    pick = wide ? $urandom_range(0, 4) : 4;
    case (pick)
      0: return tpvw_pkg::COORD_W'($urandom());
      1: begin
        case ($urandom_range(0, 3))
          0: return tpvw_pkg::COORD_W'(COORD_MIN);
          1: return tpvw_pkg::COORD_W'(COORD_MAX);
          2: return tpvw_pkg::COORD_W'(-1);
          default: return '0;
        endcase
      end
      2: return tpvw_pkg::COORD_W'(lim + int'($urandom_range(0, 3)) - 2);
      3: return tpvw_pkg::COORD_W'(int'($urandom_range(0, 3)) - 2);
      default: return (lim > 0) ? tpvw_pkg::COORD_W'($urandom_range(0, lim - 1))
                                : tpvw_pkg::COORD_W'($urandom());
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t pt;
    bit     wide;
    wide = ($urandom_range(0, 3) == 0);
    pt.x = rand_coord(vol_size[0], wide);
    pt.y = rand_coord(vol_size[1], wide);
    pt.z = rand_coord(vol_size[2], wide);
    for (int k = 0; k < tpvw_pkg::N_CORNER; k++) begin
      case ($urandom_range(0, 7))
        0: pt.corner[k] = '0;
        1: pt.corner[k] = '1;
        default: pt.corner[k] = tpvw_pkg::CORNER_W'($urandom());
      endcase
    end
    return pt;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [tpvw_pkg::APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < tpvw_pkg::N_AXIS) vol_size[idx] = val[tpvw_pkg::SIZE_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic reg_check(logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== tpvw_pkg::APB_DW'(vol_size[idx])) begin
      $display("%0t: register %0d expected %0d got %0d", $time, idx, vol_size[idx], prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_sizes(int sx, int sy, int sz);
    while (pending_res.size() != 0) @(negedge clk_i);
    reg_write(tpvw_pkg::REG_SIZE_X, tpvw_pkg::APB_DW'(sx));
    reg_write(tpvw_pkg::REG_SIZE_Y, tpvw_pkg::APB_DW'(sy));
    reg_write(tpvw_pkg::REG_SIZE_Z, tpvw_pkg::APB_DW'(sz));
    reg_write(REG_UNUSED, tpvw_pkg::APB_DW'($urandom()));
    reg_check(tpvw_pkg::REG_SIZE_X);
    reg_check(tpvw_pkg::REG_SIZE_Y);
    reg_check(tpvw_pkg::REG_SIZE_Z);
    settings_cnt++;
  endtask

  task automatic send_point(point_t pt, res_t want);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tpvw_pkg::IN_DATA_W'(pt);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_res.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic run_random(int n);
    point_t pt;
    repeat (n) begin
      pt = rand_point();
      send_point(pt, interp_point(pt));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request, none when calm
  initial begin
    @(negedge clk_i);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.in_vol = m_axis_tuser[0];
      {got.value, got.weight} = m_axis_tdata;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected beat, expected none got %h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_res.pop_front();
        beats_done++;
        if (want.in_vol) inside_cnt++;
        if (got.in_vol !== want.in_vol) begin
          $display("%0t: inside expected %0d got %0d", $time, want.in_vol, got.in_vol);
          err_cnt++;
        end
        if (got.value !== want.value) begin
          $display("%0t: value expected %0d got %0d", $time, want.value, got.value);
          err_cnt++;
        end
        for (int k = 0; k < tpvw_pkg::N_CORNER; k++) begin
          if (got.weight[k] !== want.weight[k]) begin
            $display("%0t: weight %0d expected %0d got %0d", $time, k, want.weight[k],
                     got.weight[k]);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("trilinear_partial_volume_weights_unit_test: errors");
    $finish;
  end

  initial begin
    point_t pt;
    res_t   want;
    for (int a = 0; a < tpvw_pkg::N_AXIS; a++) vol_size[a] = tpvw_pkg::SIZE_RESET;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    reg_check(tpvw_pkg::REG_SIZE_X);
    reg_check(tpvw_pkg::REG_SIZE_Y);
    reg_check(tpvw_pkg::REG_SIZE_Z);

    foreach (dir_tab[i]) begin
      pt.x = tpvw_pkg::COORD_W'(dir_tab[i].x);
      pt.y = tpvw_pkg::COORD_W'(dir_tab[i].y);
      pt.z = tpvw_pkg::COORD_W'(dir_tab[i].z);
      pt.corner = dir_tab[i].vox;
      if (dir_tab[i].typed) begin
        want = '0;
        want.in_vol = dir_tab[i].in_vol;
        want.weight[0] = tpvw_pkg::WEIGHT_W'(dir_tab[i].w000);
        want.value = tpvw_pkg::VALUE_W'(dir_tab[i].value);
      end else begin
        want = interp_point(pt);
      end
      send_point(pt, want);
    end
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    run_random(140);

    set_sizes(2, 2, 2);
    run_random(100);

    set_sizes(tpvw_pkg::MAX_SIZE, tpvw_pkg::MAX_SIZE, tpvw_pkg::MAX_SIZE);
    hold_off = 1'b1;
    run_random(150);

    set_sizes(2047, 0, 1);
    run_random(40);

    set_sizes(1025, 3, 1500);
    run_random(100);

    repeat (3) begin
      set_sizes($urandom_range(2, tpvw_pkg::MAX_SIZE), $urandom_range(2, tpvw_pkg::MAX_SIZE),
                $urandom_range(2, tpvw_pkg::MAX_SIZE));
      run_random(100);
    end

    set_sizes(tpvw_pkg::MAX_SIZE, 2, 700);
    calm = 1'b1;
    run_random(150);

    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("checked %0d result beats, %0d inside the volume, over %0d size settings",
             beats_done, inside_cnt, settings_cnt);
    $display("including edge, saturated and degenerate sizes and a long output stall");
    if (err_cnt == 0)
      $display("trilinear_partial_volume_weights_unit_test: clean");
    else
      $display("trilinear_partial_volume_weights_unit_test: errors");
    $finish;
  end

endmodule
